/* rtl/ipv4_rx_header_check_macros.svh */
// assertion macros shared by the ipv4 receive header check rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef IPV4_RX_HEADER_CHECK_MACROS_SVH
`define IPV4_RX_HEADER_CHECK_MACROS_SVH

// plain property sampled on the rising clock edge, off while in reset
`define IPV4RX_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// same-cycle implication
`define IPV4RX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPV4RX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ipv4rx_pkg.sv */
// types and constants for the ipv4 receive header check
// no dependencies
package ipv4rx_pkg;

  localparam int unsigned WordW     = 16;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned IhlW      = 4;
  localparam int unsigned HbW       = 6;
  localparam int unsigned ReasonW   = 3;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned OutDataW  = 32;

  localparam logic [3:0]       IpVersion4 = 4'd4;
  localparam logic [IhlW-1:0]  IhlMin     = 4'd5;
  localparam logic [WordW-1:0] SumGood    = 16'hFFFF;
  localparam logic [AddrW-1:0] AddrBcast  = 32'hFFFF_FFFF;
  localparam logic [IdxW-1:0]  IdxMax     = 5'd31;

  // header word positions
  localparam logic [IdxW-1:0] IdxVerIhl  = 5'd0;
  localparam logic [IdxW-1:0] IdxTotLen  = 5'd1;
  localparam logic [IdxW-1:0] IdxTtl     = 5'd4;
  localparam logic [IdxW-1:0] IdxDstHi   = 5'd8;
  localparam logic [IdxW-1:0] IdxDstLo   = 5'd9;

  typedef enum logic [ReasonW-1:0] {
    REASON_ACCEPT  = 3'd0,
    REASON_VERSION = 3'd1,
    REASON_HDR_LEN = 3'd2,
    REASON_TTL     = 3'd3,
    REASON_CSUM    = 3'd4,
    REASON_DEST    = 3'd5
  } reason_e;

  typedef struct packed {
    logic             valid;
    reason_e          reason;
    logic [HbW-1:0]   header_bytes;
    logic [WordW-1:0] payload_length;
  } verdict_t;

endpackage

/* rtl/ipv4rx_core.sv */
// per-word header state and verdict logic for the ipv4 receive header check
// depends on ipv4rx_pkg
module ipv4rx_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic [ipv4rx_pkg::WordW-1:0]       word_i,
  input  logic                               last_i,
  input  logic [ipv4rx_pkg::AddrW-1:0]       local_addr_i,
  output ipv4rx_pkg::verdict_t               verdict_o
);

  logic [ipv4rx_pkg::IdxW-1:0]  word_index_q, word_index_d;
  logic [ipv4rx_pkg::WordW-1:0] sum_acc_q, sum_acc_d;
  logic [ipv4rx_pkg::IhlW-1:0]  ihl_q, ihl_d;
  logic [ipv4rx_pkg::WordW-1:0] tot_len_q, tot_len_d;
  logic [ipv4rx_pkg::AddrW-1:0] dest_q, dest_d;
  logic                         done_q, done_d;

  logic [ipv4rx_pkg::WordW:0]   sum_wide;
  logic [ipv4rx_pkg::WordW-1:0] sum_new;
  logic [ipv4rx_pkg::IhlW-1:0]  ihl_new;
  logic [ipv4rx_pkg::WordW-1:0] tot_len_new;
  logic [ipv4rx_pkg::AddrW-1:0] dest_new;
  logic [ipv4rx_pkg::HbW-1:0]   hb;
  logic [ipv4rx_pkg::HbW-1:0]   last_hdr_idx;
  logic                         have_len;
  logic                         ver_fail, ihl_fail, ttl_fail, hdr_end;
  logic                         active;

  assign active   = step_i && !done_q;
  assign sum_wide = {1'b0, sum_acc_q} + {1'b0, word_i};
  // end-around carry
  assign sum_new  = sum_wide[ipv4rx_pkg::WordW-1:0] +
                    {{(ipv4rx_pkg::WordW-1){1'b0}}, sum_wide[ipv4rx_pkg::WordW]};

  assign ihl_new     = (word_index_q == ipv4rx_pkg::IdxVerIhl) ? word_i[11:8] : ihl_q;
  assign tot_len_new = (word_index_q == ipv4rx_pkg::IdxTotLen) ? word_i : tot_len_q;

  always_comb begin
    dest_new = dest_q;
    if (word_index_q == ipv4rx_pkg::IdxDstHi) begin
      dest_new[31:16] = word_i;
    end else if (word_index_q == ipv4rx_pkg::IdxDstLo) begin
      dest_new[15:0] = word_i;
    end
  end

  assign hb           = {ihl_new, 2'b00};
  // 6 bits so that an ihl of zero never matches
  assign last_hdr_idx = {1'b0, ihl_new, 1'b0} - 6'd1;
  assign have_len     = (word_index_q != ipv4rx_pkg::IdxVerIhl);

  assign ver_fail = (word_index_q == ipv4rx_pkg::IdxVerIhl) &&
                    (word_i[15:12] != ipv4rx_pkg::IpVersion4);
  assign ihl_fail = (word_index_q == ipv4rx_pkg::IdxVerIhl) &&
                    (word_i[11:8] < ipv4rx_pkg::IhlMin);
  assign ttl_fail = (word_index_q == ipv4rx_pkg::IdxTtl) && (word_i[15:8] == 8'd0);
  assign hdr_end  = have_len && ({1'b0, word_index_q} == last_hdr_idx);

  always_comb begin
    verdict_o.valid        = 1'b0;
    verdict_o.reason       = ipv4rx_pkg::REASON_ACCEPT;
    verdict_o.header_bytes = hb;
    verdict_o.payload_length = have_len ? (tot_len_new - {10'd0, hb}) : '0;
    priority if (ver_fail) begin
      verdict_o.valid  = active;
      verdict_o.reason = ipv4rx_pkg::REASON_VERSION;
    end else if (ihl_fail) begin
      verdict_o.valid  = active;
      verdict_o.reason = ipv4rx_pkg::REASON_HDR_LEN;
    end else if (ttl_fail) begin
      verdict_o.valid  = active;
      verdict_o.reason = ipv4rx_pkg::REASON_TTL;
    end else if (hdr_end) begin
      verdict_o.valid = active;
      if (sum_new != ipv4rx_pkg::SumGood) begin
        verdict_o.reason = ipv4rx_pkg::REASON_CSUM;
      end else if (dest_new == local_addr_i || dest_new == ipv4rx_pkg::AddrBcast) begin
        verdict_o.reason = ipv4rx_pkg::REASON_ACCEPT;
      end else begin
        verdict_o.reason = ipv4rx_pkg::REASON_DEST;
      end
    end else if (last_i) begin
      // packet ended inside its header
      verdict_o.valid  = active;
      verdict_o.reason = ipv4rx_pkg::REASON_HDR_LEN;
    end else begin
      // word inside the header or payload that decides nothing
      verdict_o.valid  = 1'b0;
    end
  end

  always_comb begin
    word_index_d = word_index_q;
    sum_acc_d    = sum_acc_q;
    ihl_d        = ihl_q;
    tot_len_d    = tot_len_q;
    dest_d       = dest_q;
    done_d       = done_q;
    if (active) begin
      sum_acc_d    = sum_new;
      ihl_d        = ihl_new;
      tot_len_d    = tot_len_new;
      dest_d       = dest_new;
      word_index_d = (word_index_q < ipv4rx_pkg::IdxMax) ? word_index_q + 5'd1
                                                           : ipv4rx_pkg::IdxMax;
      done_d       = verdict_o.valid;
    end
    if (step_i && last_i) begin
      word_index_d = '0;
      sum_acc_d    = '0;
      done_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_index_q <= '0;
      sum_acc_q    <= '0;
      ihl_q        <= '0;
      tot_len_q    <= '0;
      dest_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      word_index_q <= word_index_d;
      sum_acc_q    <= sum_acc_d;
      ihl_q        <= ihl_d;
      tot_len_q    <= tot_len_d;
      dest_q       <= dest_d;
      done_q       <= done_d;
    end
  end

endmodule

/* rtl/ipv4_rx_header_check.sv */
// ipv4 receive header check, top level: input stage, verdict core, result register
// depends on ipv4rx_pkg, ipv4rx_core and ipv4_rx_header_check_macros.svh
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata: pkt_word; tlast: last_word
//  m_axis    out  m_axis_tvalid/tready        tdata: reason, header_bytes, payload_length
//  cfg       in   cfg_we_i                    cfg_wdata_i: local_addr
//
// one packet word per cycle sustained unless the result is stalled; a word passes
// the input register, then the verdict core into the result register
// at most one verdict per packet, on the word that decides it
// a stalled result holds the core and a full input stage; an empty input stage still takes one more word
// reset clears the per-packet state and local_addr to zero
`include "ipv4_rx_header_check_macros.svh"

module ipv4_rx_header_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pkt_word
  input  logic        s_axis_tlast,   // last_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] reason, [8:3] header_bytes,
                                      // [24:9] payload_length, [31:25] zero
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [ipv4rx_pkg::AddrW-1:0] local_addr_q;
  logic                         in_vld_q;
  logic [ipv4rx_pkg::WordW-1:0] in_word_q;
  logic                         in_last_q;
  logic                         in_adv;
  logic                         out_vld_q;
  ipv4rx_pkg::verdict_t         verdict;
  ipv4rx_pkg::reason_e          out_reason_q;
  logic [ipv4rx_pkg::HbW-1:0]   out_hb_q;
  logic [ipv4rx_pkg::WordW-1:0] out_plen_q;
  logic                         out_free;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign in_adv        = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
    end else if (cfg_we_i) begin
      local_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  ipv4rx_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_adv),
    .word_i       (in_word_q),
    .last_i       (in_last_q),
    .local_addr_i (local_addr_q),
    .verdict_o    (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= verdict.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && verdict.valid) begin
      out_reason_q <= verdict.reason;
      out_hb_q     <= verdict.header_bytes;
      out_plen_q   <= verdict.payload_length;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_plen_q, out_hb_q, out_reason_q};

  // a word waiting on a stalled result must not be dropped
  `IPV4RX_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_vld_q && !out_free, in_vld_q, "input word lost while stalled")
  // a verdict is only produced by a word that moves through the core
  `IPV4RX_ASSERT_IMP(a_verdict_step, clk_i, rst_ni, verdict.valid, in_adv, "verdict without core step")
  // an accepted packet always had a legal header length
  `IPV4RX_ASSERT_IMP(a_accept_hb, clk_i, rst_ni, out_vld_q && out_reason_q == ipv4rx_pkg::REASON_ACCEPT, out_hb_q >= 6'd20, "accept with short header")
  // a version failure is judged before total length is known
  `IPV4RX_ASSERT_IMP(a_early_plen, clk_i, rst_ni, out_vld_q && out_reason_q == ipv4rx_pkg::REASON_VERSION, out_plen_q == 16'd0, "version failure with payload length")

endmodule

/* test/ipv4_rx_header_check_tb.sv */
// self-checking testbench for ipv4_rx_header_check: streams whole packets in and
// checks every verdict against an in-bench model of the header checks
// depends on ipv4rx_pkg and the ipv4_rx_header_check rtl
`timescale 1ns / 100ps

module ipv4_rx_header_check_tb;

  typedef struct packed {
    logic [ipv4rx_pkg::WordW-1:0] word;
    logic                         last;
  } in_xfer_t;

  typedef struct packed {
    ipv4rx_pkg::reason_e          reason;
    logic [ipv4rx_pkg::HbW-1:0]   hdr_bytes;
    logic [ipv4rx_pkg::WordW-1:0] pay_len;
  } verdict_exp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;

  in_xfer_t     pending_words [$];
  verdict_exp_t exp_verdicts  [$];

  // model of the block's per-packet state
  logic [ipv4rx_pkg::IdxW-1:0]  hdr_idx   = '0;
  logic [ipv4rx_pkg::WordW-1:0] hdr_sum   = '0;
  logic [ipv4rx_pkg::IhlW-1:0]  ihl_q     = '0;
  logic [7:0]                   ttl_q     = '0;
  logic [ipv4rx_pkg::WordW-1:0] tot_len_q = '0;
  logic [ipv4rx_pkg::AddrW-1:0] dst_q     = '0;
  logic                         decided   = 1'b0;
  logic [ipv4rx_pkg::AddrW-1:0] my_addr   = '0;

  bit          in_taken  = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned in_gap    = 0;
  int unsigned in_calm   = 0;
  int unsigned out_stall = 0;
  int unsigned out_calm  = 0;

  int unsigned errors        = 0;
  int unsigned words_queued  = 0;
  int unsigned pkts_queued   = 0;
  int unsigned addr_settings = 0;
  int unsigned reason_seen [6];

  ipv4_rx_header_check u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // mostly short waits, now and then a long one, and runs of back-to-back transfers
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(16, 64);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 1);
  endfunction

  // advance the header model by one accepted word
  function automatic void predict_word(input logic [ipv4rx_pkg::WordW-1:0] w,
                                       input logic last);
    logic [16:0]                s;
    logic                       have_len;
    logic                       hit;
    ipv4rx_pkg::reason_e        r;
    logic [ipv4rx_pkg::HbW-1:0] hb;
    verdict_exp_t               e;
    if (!decided) begin
      have_len = (hdr_idx != ipv4rx_pkg::IdxVerIhl);
      hit      = 1'b0;
      r        = ipv4rx_pkg::REASON_ACCEPT;
      s        = {1'b0, hdr_sum} + {1'b0, w};
      hdr_sum  = s[15:0] + {15'd0, s[16]};
      case (hdr_idx)
        ipv4rx_pkg::IdxVerIhl: begin
          ihl_q = w[11:8];
          if (w[15:12] != ipv4rx_pkg::IpVersion4) begin
            r   = ipv4rx_pkg::REASON_VERSION;
            hit = 1'b1;
          end else if (w[11:8] < ipv4rx_pkg::IhlMin) begin
            r   = ipv4rx_pkg::REASON_HDR_LEN;
            hit = 1'b1;
          end
        end
        ipv4rx_pkg::IdxTotLen: tot_len_q = w;
        ipv4rx_pkg::IdxTtl: begin
          ttl_q = w[15:8];
          if (ttl_q == 8'd0) begin
            r   = ipv4rx_pkg::REASON_TTL;
            hit = 1'b1;
          end
        end
        ipv4rx_pkg::IdxDstHi: dst_q[31:16] = w;
        ipv4rx_pkg::IdxDstLo: dst_q[15:0]  = w;
        default: ;
      endcase
      // checksum and destination on the last header word
      if (!hit && have_len && int'(hdr_idx) == int'(ihl_q) * 2 - 1) begin
        if (hdr_sum != ipv4rx_pkg::SumGood) r = ipv4rx_pkg::REASON_CSUM;
        else if (dst_q == my_addr || dst_q == ipv4rx_pkg::AddrBcast)
          r = ipv4rx_pkg::REASON_ACCEPT;
        else r = ipv4rx_pkg::REASON_DEST;
        hit = 1'b1;
      end
      // packet ran out before its header did
      if (!hit && last) begin
        r   = ipv4rx_pkg::REASON_HDR_LEN;
        hit = 1'b1;
      end
      hdr_idx = (hdr_idx < ipv4rx_pkg::IdxMax) ? hdr_idx + 1'b1 : ipv4rx_pkg::IdxMax;
      if (hit) begin
        hb          = {ihl_q, 2'b00};
        e.reason    = r;
        e.hdr_bytes = hb;
        e.pay_len   = have_len ? tot_len_q - {10'd0, hb} : '0;
        exp_verdicts.push_back(e);
        decided = 1'b1;
      end
    end
    if (last) begin
      hdr_idx = '0;
      hdr_sum = '0;
      decided = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("%0t ns: verdict %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic check_verdict(input logic [31:0] d);
    verdict_exp_t e;
    if (exp_verdicts.size() == 0) begin
      report_mismatch("without packet", d, '0);
      return;
    end
    e = exp_verdicts.pop_front();
    reason_seen[e.reason]++;
    if (d[2:0] != e.reason) report_mismatch("reason", d[2:0], e.reason);
    if (d[8:3] != e.hdr_bytes) report_mismatch("header_bytes", d[8:3], e.hdr_bytes);
    if (d[24:9] != e.pay_len) report_mismatch("payload_length", d[24:9], e.pay_len);
    if (d[31:25] != '0) report_mismatch("padding", d[31:25], '0);
  endtask

  // build one packet with a correct header checksum unless told otherwise;
  // cut_len > 0 truncates the packet to that many words
  task automatic queue_packet(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [7:0] ttl, input logic [15:0] tot_len,
                              input logic [31:0] dst, input int unsigned n_payload,
                              input bit bad_sum, input int unsigned cut_len);
    logic [15:0] pkt [$];
    logic [16:0] s;
    logic [15:0] acc;
    int unsigned n_hdr;
    in_xfer_t    x;
    n_hdr = (ihl < ipv4rx_pkg::IhlMin) ? 10 : int'(ihl) * 2;
    for (int i = 0; i < n_hdr; i++) pkt.push_back(16'($urandom));
    pkt[0] = {ver, ihl, 8'($urandom)};
    pkt[1] = tot_len;
    pkt[4] = {ttl, 8'($urandom)};
    pkt[5] = '0;
    pkt[8] = dst[31:16];
    pkt[9] = dst[15:0];
    acc = '0;
    for (int i = 0; i < n_hdr; i++) begin
      s   = {1'b0, acc} + {1'b0, pkt[i]};
      acc = s[15:0] + {15'd0, s[16]};
    end
    pkt[5] = ~acc;
    if (bad_sum) pkt[5] = pkt[5] ^ 16'($urandom_range(1, 16'hFFFF));
    for (int i = 0; i < n_payload; i++) pkt.push_back(16'($urandom));
    if (cut_len > 0 && cut_len < pkt.size()) pkt = pkt[0:cut_len-1];
    foreach (pkt[i]) begin
      x.word = pkt[i];
      x.last = (i == pkt.size() - 1);
      pending_words.push_back(x);
    end
    words_queued += pkt.size();
    pkts_queued++;
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || s_axis_tvalid || exp_verdicts.size() != 0)
      @(posedge clk_i);
    // room for a trailing word that gives no verdict
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_local_addr(input logic [31:0] a);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    my_addr  = a;
    addr_settings++;
  endtask

  // packet source
  always @(negedge clk_i) begin
    in_xfer_t nx;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (in_taken) in_gap = draw_wait(in_calm);
      if (in_gap == 0 && pending_words.size() != 0) begin
        nx = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nx.word;
        s_axis_tlast  <= nx.last;
      end else begin
        if (in_gap != 0) in_gap--;
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // verdict sink back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) out_stall = draw_wait(out_calm);
      if (out_stall != 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // sample both transfers at the rising edge
  always @(posedge clk_i) begin
    in_taken  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) predict_word(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_verdict(m_axis_tdata);
  end

  initial begin
    logic [31:0] a;
    logic [3:0]  ihl;
    logic [31:0] dst;
    int unsigned n_pay;
    int unsigned n_hdr;
    logic [15:0] tlen;
    int unsigned phase_words;
    int unsigned phase;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    a = $urandom;
    write_local_addr(a);
    // directed packets
    queue_packet(4'h0, 4'd5, 8'd64, 16'd20, a, 0, 0, 3);          // bad version, rest ignored
    queue_packet(4'hF, 4'd15, 8'd64, 16'd60, a, 0, 0, 1);         // bad version, one word
    queue_packet(4'h4, 4'd0, 8'd64, 16'd20, a, 0, 0, 2);          // ihl zero
    queue_packet(4'h4, 4'd4, 8'd64, 16'd20, a, 0, 0, 0);          // ihl just below minimum
    queue_packet(4'h4, 4'd5, 8'd64, 16'd20, a, 0, 0, 1);          // ends on first word
    queue_packet(4'h4, 4'd5, 8'd64, 16'd40, a, 0, 0, 4);          // ends after total length
    queue_packet(4'h4, 4'd5, 8'd0, 16'd24, a, 2, 0, 0);           // ttl expired
    queue_packet(4'h4, 4'd5, 8'd128, 16'd20, a, 0, 0, 0);         // accept, verdict on last
    queue_packet(4'h4, 4'd5, 8'd1, 16'd24, 32'hFFFF_FFFF, 2, 0, 0); // broadcast
    queue_packet(4'h4, 4'd5, 8'd255, 16'd20, ~a, 0, 0, 0);        // foreign destination
    queue_packet(4'h4, 4'd5, 8'd64, 16'd26, a, 3, 1, 0);          // corrupt checksum
    queue_packet(4'h4, 4'd5, 8'd64, 16'd0, a, 0, 0, 0);           // payload length wraps
    queue_packet(4'h4, 4'd5, 8'd64, 16'hFFFF, a, 1, 0, 0);        // largest total length
    queue_packet(4'h4, 4'd15, 8'd64, 16'd160, a, 40, 0, 0);       // longest header, long tail
    queue_packet(4'h4, 4'd6, 8'd64, 16'd24, a, 0, 0, 11);         // cut one word short

    phase = 0;
    while (words_queued < 1450) begin
      phase++;
      a = (phase == 1) ? 32'd0 : (phase == 2) ? 32'hFFFF_FFFF : $urandom;
      write_local_addr(a);
      phase_words = words_queued;
      while (words_queued - phase_words < 250 && words_queued < 1450) begin
        ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        n_hdr = int'(ihl) * 2;
        n_pay = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 12);
        tlen  = ($urandom_range(0, 3) != 0) ? 16'(n_hdr * 2 + n_pay * 2) : 16'($urandom);
        case ($urandom_range(0, 3))
          0, 1:    dst = my_addr;
          2:       dst = ipv4rx_pkg::AddrBcast;
          default: dst = $urandom;
        endcase
        case ($urandom_range(0, 9))
          6: queue_packet(4'h4, ihl, 8'($urandom_range(1, 255)), tlen, dst, n_pay, 1, 0);
          7: queue_packet(4'h4, ihl, 8'd0, tlen, dst, n_pay, 0, 0);
          8: queue_packet(4'h4, ihl, 8'($urandom_range(1, 255)), tlen, dst, n_pay, 0,
                          $urandom_range(1, n_hdr - 1));
          9: queue_packet(4'($urandom), 4'($urandom), 8'($urandom), 16'($urandom), $urandom,
                          $urandom_range(0, 6), $urandom_range(0, 1), $urandom_range(0, 14));
          default:
             queue_packet(4'h4, ihl, 8'($urandom_range(1, 255)), tlen, dst, n_pay, 0, 0);
        endcase
      end
    end

    settle();
    $display("ran %0d packets (%0d words) under %0d local address settings",
             pkts_queued, words_queued, addr_settings);
    $display("verdicts: accept %0d, version %0d, hdr len %0d, ttl %0d, csum %0d, dest %0d",
             reason_seen[0], reason_seen[1], reason_seen[2], reason_seen[3],
             reason_seen[4], reason_seen[5]);
    if (errors == 0 && exp_verdicts.size() == 0) begin
      $display("** ipv4_rx_header_check: PASSED **");
    end else begin
      $display("** ipv4_rx_header_check: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timed out with %0d verdicts outstanding", exp_verdicts.size());
    $display("** ipv4_rx_header_check: FAILED **");
    $finish;
  end

endmodule
